FILE: rtl/bapt_pkg.sv
// ============================================================================
// bapt_pkg
// Shared widths, calibration tables and control types for the block-average
// piecewise temperature converter.
// ============================================================================
package bapt_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 20;
    localparam int CNT_W    = 9;
    localparam int TEMP_W   = 12;

    // Pipeline stages behind the accumulators, ahead of the output register
    localparam int PIPE_DEPTH = 7;

    // Calibration datapath widths
    localparam int SLOPE_W = 11;   // largest slope 1270
    localparam int OFFS_W  = 22;   // largest offset 3868000
    localparam int PROD_W  = 23;   // 1270 * 4095 < 2^23
    localparam int DIFF_W  = 24;   // signed numerator
    localparam int MAG_W   = 21;   // |numerator| <= 1332650
    localparam int QUO_W   = 11;   // |temperature| <= 1332

    // Divide by 1000: floor(x * M / 2^31) is exact for x < 2^21
    localparam int                DIV1000_SH = 31;
    localparam logic [21:0]       DIV1000_M  = 22'd2147484;

    localparam int SEG_N = 7;
    localparam int SEG_W = 3;

    typedef logic [SEG_W-1:0] seg_t;

    // Segment breakpoints (lower bound of segments one through six)
    localparam logic [SAMPLE_W-1:0] BP_1 = 12'd796;
    localparam logic [SAMPLE_W-1:0] BP_2 = 12'd1192;
    localparam logic [SAMPLE_W-1:0] BP_3 = 12'd2536;
    localparam logic [SAMPLE_W-1:0] BP_4 = 12'd3058;
    localparam logic [SAMPLE_W-1:0] BP_5 = 12'd3424;
    localparam logic [SAMPLE_W-1:0] BP_6 = 12'd3470;

    // Per-segment slope and offset: temp = (slope * avg - offset) / 1000
    localparam logic [SLOPE_W-1:0] SLOPE_TAB [SEG_N] = '{
        11'd380, 11'd275, 11'd228, 11'd288, 11'd410, 11'd700, 11'd1270
    };

    localparam logic [OFFS_W-1:0] OFFS_TAB [SEG_N] = '{
        22'd358600, 22'd272800, 22'd213700, 22'd366500,
        22'd741000, 22'd1731000, 22'd3868000
    };

    // Lane control, one word per cycle
    typedef struct packed {
        logic adv;     // pipeline shifts this cycle
        logic add;     // accumulate the accepted word
        logic clear;   // clear the accumulator
    } bapt_ctrl_t;

    // Segment select from the average
    function automatic seg_t bapt_seg(input logic [SAMPLE_W-1:0] avg);
        seg_t s;
        priority if (avg < BP_1) s = 3'd0;
        else if (avg < BP_2)     s = 3'd1;
        else if (avg < BP_3)     s = 3'd2;
        else if (avg < BP_4)     s = 3'd3;
        else if (avg < BP_5)     s = 3'd4;
        else if (avg < BP_6)     s = 3'd5;
        else                     s = 3'd6;
        return s;
    endfunction

endpackage

FILE: rtl/bapt_calib.sv
// ============================================================================
// bapt_calib
// Three-stage piecewise-linear calibration of one average to temperature,
// with signed division by 1000 truncating toward zero.
// ============================================================================
module bapt_calib
    import bapt_pkg::*;
(
    input  logic                       clk,
    input  logic                       adv,
    input  logic [SAMPLE_W-1:0]        avg_in,
    output logic [SAMPLE_W-1:0]        avg_out,
    output logic signed [TEMP_W-1:0]   temp_out
);

    // Stage 1: slope multiply and offset select
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [OFFS_W-1:0]   offs_reg, offs_next;
    logic [SAMPLE_W-1:0] avg1_reg;
    seg_t                seg;

    // Stage 2: numerator sign and magnitude
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                neg2_reg, neg2_next;
    logic [SAMPLE_W-1:0] avg2_reg;

    // Stage 3: magnitude / 1000
    logic [MAG_W+22-1:0] qprod;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic                neg3_reg;
    logic [SAMPLE_W-1:0] avg3_reg;

    logic signed [TEMP_W-1:0] quo_s;

    // Segment lookup and slope product
    always_comb
    begin
        seg       = bapt_seg(avg_in);
        prod_next = PROD_W'(avg_in) * PROD_W'(SLOPE_TAB[seg]);
        offs_next = OFFS_TAB[seg];
    end

    // Subtract offset, split into sign and magnitude
    always_comb
    begin
        diff      = signed'({1'b0, prod_reg}) - signed'({2'b00, offs_reg});
        neg2_next = diff[DIFF_W-1];
        mag_next  = neg2_next ? MAG_W'(-diff) : MAG_W'(diff);
    end

    // Reciprocal multiply, exact over the magnitude range
    always_comb
    begin
        qprod    = (MAG_W+22)'(mag_reg) * (MAG_W+22)'(DIV1000_M);
        quo_next = qprod[DIV1000_SH +: QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            offs_reg <= offs_next;
            avg1_reg <= avg_in;
            mag_reg  <= mag_next;
            neg2_reg <= neg2_next;
            avg2_reg <= avg1_reg;
            quo_reg  <= quo_next;
            neg3_reg <= neg2_reg;
            avg3_reg <= avg2_reg;
        end
    end

    // Restore sign
    assign quo_s    = signed'(TEMP_W'(quo_reg));
    assign temp_out = neg3_reg ? -quo_s : quo_s;
    assign avg_out  = avg3_reg;

endmodule

FILE: rtl/bapt_lane.sv
// ============================================================================
// bapt_lane
// One channel lane: sample accumulator, divide-by-count pipeline and
// temperature calibration.
// ============================================================================
module bapt_lane
    import bapt_pkg::*;
#(
    parameter int SAMPLE_COUNT = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bapt_ctrl_t                 ctrl,
    input  logic [SAMPLE_W-1:0]        sample,
    output logic [SAMPLE_W-1:0]        average,
    output logic signed [TEMP_W-1:0]   temperature
);

    // floor(2^31 / N); the estimate sum * R >> 31 is the quotient or one less
    localparam int          RECIP_SH = 31;
    localparam logic [31:0] RECIP    = 32'((64'd1 << RECIP_SH) / SAMPLE_COUNT);
    localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(SAMPLE_COUNT);

    logic [SUM_W-1:0]    sum_reg, sum_next;

    // Stage 1: captured block sum
    logic [SUM_W-1:0]    cap_reg;
    // Stage 2: quotient estimate
    logic [SUM_W+32-1:0] eprod;
    logic [SAMPLE_W-1:0] qest2_reg;
    logic [SUM_W-1:0]    sum2_reg;
    // Stage 3: estimate times count
    logic [SUM_W-1:0]    nq_reg, nq_next;
    logic [SAMPLE_W-1:0] qest3_reg;
    logic [SUM_W-1:0]    sum3_reg;
    // Stage 4: corrected average
    logic [SUM_W-1:0]    rem;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;

    // Accumulator
    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.clear)
            sum_next = '0;
        else if (ctrl.add)
            sum_next = sum_reg + SUM_W'(sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    // Divider datapath
    always_comb
    begin
        eprod    = (SUM_W+32)'(cap_reg) * (SUM_W+32)'(RECIP);
        nq_next  = SUM_W'(SUM_W'(qest2_reg) * DIVISOR);
        rem      = sum3_reg - nq_reg;
        avg_next = (rem >= DIVISOR) ? qest3_reg + 1'b1 : qest3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            cap_reg   <= sum_reg;
            qest2_reg <= eprod[RECIP_SH +: SAMPLE_W];
            sum2_reg  <= cap_reg;
            nq_reg    <= nq_next;
            qest3_reg <= qest2_reg;
            sum3_reg  <= sum2_reg;
            avg_reg   <= avg_next;
        end
    end

    bapt_calib u_calib
    (
        .clk      (clk),
        .adv      (ctrl.adv),
        .avg_in   (avg_reg),
        .avg_out  (average),
        .temp_out (temperature)
    );

endmodule

FILE: rtl/bapt_merge.sv
// ============================================================================
// bapt_merge
// Joins both lane results into one output word behind a register and
// derives the pipeline advance from the output handshake.
// ============================================================================
module bapt_merge
    import bapt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       last_valid,
    input  logic [SAMPLE_W-1:0]        avg0_in,
    input  logic [SAMPLE_W-1:0]        avg1_in,
    input  logic signed [TEMP_W-1:0]   temp0_in,
    input  logic signed [TEMP_W-1:0]   temp1_in,
    output logic                       adv,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [SAMPLE_W-1:0]        average_ch0,
    output logic [SAMPLE_W-1:0]        average_ch1,
    output logic signed [TEMP_W-1:0]   temperature_ch0,
    output logic signed [TEMP_W-1:0]   temperature_ch1
);

    logic                     valid_reg;
    logic [SAMPLE_W-1:0]      avg0_reg, avg1_reg;
    logic signed [TEMP_W-1:0] temp0_reg, temp1_reg;

    // Pipeline moves when the output slot is free or being drained
    assign adv = !valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= last_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            avg0_reg  <= avg0_in;
            avg1_reg  <= avg1_in;
            temp0_reg <= temp0_in;
            temp1_reg <= temp1_in;
        end
    end

    assign result_valid    = valid_reg;
    assign average_ch0     = avg0_reg;
    assign average_ch1     = avg1_reg;
    assign temperature_ch0 = temp0_reg;
    assign temperature_ch1 = temp1_reg;

endmodule

FILE: rtl/block_average_piecewise_temperature_top.sv
// ============================================================================
// block_average_piecewise_temperature_top
// Two-channel block averager with piecewise-linear temperature calibration.
// ============================================================================
// Pipeline: after its emitting sample word is accepted, a result word becomes
//   valid behind 4 divide stages, 3 calibration stages and 1 output register.
// Throughput: one sample word per cycle; accumulating words are taken even
//   while a result waits; an emitting word waits only for the pipeline shift.
// Reset: rst_n asynchronously clears accumulators, poll count and valids.
// ============================================================================
module block_average_piecewise_temperature_top
    import bapt_pkg::*;
#(
    parameter int SAMPLE_COUNT = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic [SAMPLE_W-1:0]        sample_ch0,
    input  logic [SAMPLE_W-1:0]        sample_ch1,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [SAMPLE_W-1:0]        average_ch0,
    output logic [SAMPLE_W-1:0]        average_ch1,
    output logic signed [TEMP_W-1:0]   temperature_ch0,
    output logic signed [TEMP_W-1:0]   temperature_ch1
);

    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(SAMPLE_COUNT);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;
    logic                  adv;
    logic                  fire;
    logic                  at_limit;
    logic                  over;
    logic                  emit;
    bapt_ctrl_t            ctrl;

    logic [SAMPLE_W-1:0]      avg0, avg1;
    logic signed [TEMP_W-1:0] temp0, temp1;

    // Poll decode
    assign at_limit     = (count_reg == N_CNT);
    assign over         = (count_reg > N_CNT);
    assign sample_ready = !at_limit || adv;
    assign fire         = sample_valid && sample_ready;
    assign emit         = fire && at_limit;

    always_comb
    begin
        ctrl.adv   = adv;
        ctrl.add   = fire && !at_limit && !over;
        ctrl.clear = fire && (at_limit || over);
    end

    // Poll count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
            count_next = '0;
        else if (ctrl.add)
            count_next = count_reg + 1'b1;
    end

    // Result valid chain alongside the lane pipelines
    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
            vld_next = {vld_reg[PIPE_DEPTH-2:0], emit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            vld_reg   <= vld_next;
        end
    end

    // Channel lanes
    bapt_lane #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_lane0
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample      (sample_ch0),
        .average     (avg0),
        .temperature (temp0)
    );

    bapt_lane #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_lane1
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .sample      (sample_ch1),
        .average     (avg1),
        .temperature (temp1)
    );

    // Output merge
    bapt_merge u_merge
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .last_valid      (vld_reg[PIPE_DEPTH-1]),
        .avg0_in         (avg0),
        .avg1_in         (avg1),
        .temp0_in        (temp0),
        .temp1_in        (temp1),
        .adv             (adv),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .average_ch0     (average_ch0),
        .average_ch1     (average_ch1),
        .temperature_ch0 (temperature_ch0),
        .temperature_ch1 (temperature_ch1)
    );

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= N_CNT)
        else $error("poll count beyond block size");

    a_emit_launch: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> vld_reg[0] && count_reg == '0)
        else $error("emitting word did not launch a result");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(vld_reg[PIPE_DEPTH-1]))
        else $error("result word without a pipeline source");

endmodule

FILE: tb/bapt_reading_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// bapt_reading_checker
// Watches both channels of the block-average temperature converter, keeps its
// own copy of the accumulators and poll count, and works out the averages and
// calibrated temperatures that each emitting poll must produce. Every result
// word is compared field by field with the oldest predicted reading.
// ============================================================================
module bapt_reading_checker
    import bapt_pkg::*;
#(
    parameter int SAMPLE_COUNT = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    input  logic                       sample_ready,
    input  logic [SAMPLE_W-1:0]        sample_ch0,
    input  logic [SAMPLE_W-1:0]        sample_ch1,
    input  logic                       result_valid,
    input  logic                       result_ready,
    input  logic [SAMPLE_W-1:0]        average_ch0,
    input  logic [SAMPLE_W-1:0]        average_ch1,
    input  logic signed [TEMP_W-1:0]   temperature_ch0,
    input  logic signed [TEMP_W-1:0]   temperature_ch1,
    output int unsigned                mismatch_count,
    output int unsigned                readings_pending
);

    typedef struct {
        logic [SAMPLE_W-1:0]        avg0;
        logic [SAMPLE_W-1:0]        avg1;
        logic signed [TEMP_W-1:0]   temp0;
        logic signed [TEMP_W-1:0]   temp1;
    } reading_t;

    // Model state
    logic [SUM_W-1:0] acc_ch0;
    logic [SUM_W-1:0] acc_ch1;
    logic [CNT_W-1:0] polls_taken;
    reading_t         expected_readings [$];
    int unsigned      errors;

    // Seven-segment calibration, signed, quotient truncated toward zero
    function automatic logic signed [TEMP_W-1:0] calibrate(input logic [SAMPLE_W-1:0] avg);
        longint level;
        longint numer;
        longint quot;
        level = longint'(avg);
        if (avg < 12'd796)
            numer = 380 * level - 358600;
        else if (avg < 12'd1192)
            numer = 275 * level - 272800;
        else if (avg < 12'd2536)
            numer = 228 * level - 213700;
        else if (avg < 12'd3058)
            numer = 288 * level - 366500;
        else if (avg < 12'd3424)
            numer = 410 * level - 741000;
        else if (avg < 12'd3470)
            numer = 700 * level - 1731000;
        else
            numer = 1270 * level - 3868000;
        quot = numer / 1000;
        return quot[TEMP_W-1:0];
    endfunction

    task automatic check_field(input string label, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // Track accepted words, predict and compare
    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t         rd;
        reading_t         want;
        logic [SUM_W-1:0] mean0;
        logic [SUM_W-1:0] mean1;
        if (!rst_n)
        begin
            acc_ch0     = '0;
            acc_ch1     = '0;
            polls_taken = '0;
            errors      = 0;
            expected_readings.delete();
        end
        else
        begin
            // Sample side
            if (sample_valid && sample_ready)
            begin
                if (polls_taken == CNT_W'(SAMPLE_COUNT))
                begin
                    // emitting poll: its own samples are dropped
                    mean0    = acc_ch0 / SUM_W'(SAMPLE_COUNT);
                    mean1    = acc_ch1 / SUM_W'(SAMPLE_COUNT);
                    rd.avg0  = mean0[SAMPLE_W-1:0];
                    rd.avg1  = mean1[SAMPLE_W-1:0];
                    rd.temp0 = calibrate(rd.avg0);
                    rd.temp1 = calibrate(rd.avg1);
                    expected_readings.push_back(rd);
                    acc_ch0     = '0;
                    acc_ch1     = '0;
                    polls_taken = '0;
                end
                else if (polls_taken > CNT_W'(SAMPLE_COUNT))
                begin
                    // unreachable from reset; clears without a result
                    acc_ch0     = '0;
                    acc_ch1     = '0;
                    polls_taken = '0;
                end
                else
                begin
                    acc_ch0     = acc_ch0 + SUM_W'(sample_ch0);
                    acc_ch1     = acc_ch1 + SUM_W'(sample_ch1);
                    polls_taken = polls_taken + 1'b1;
                end
            end

            // Result side
            if (result_valid && result_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result word, expected none, got %0d %0d %0d %0d",
                             $time, average_ch0, average_ch1, temperature_ch0, temperature_ch1);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("average_ch0", int'(want.avg0), int'(average_ch0));
                    check_field("average_ch1", int'(want.avg1), int'(average_ch1));
                    check_field("temperature_ch0", int'(want.temp0), int'(temperature_ch0));
                    check_field("temperature_ch1", int'(want.temp1), int'(temperature_ch1));
                end
            end
        end
        mismatch_count   <= errors;
        readings_pending <= expected_readings.size();
    end

endmodule

FILE: tb/block_average_piecewise_temperature_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// block_average_piecewise_temperature_top_tb
// Drives sample pairs into the block in bursts, one directed full-scale block
// followed by random blocks aimed at the calibration breakpoints, while the
// result side stalls on its own pattern with long hold-offs. Checking is done
// by the reading checker beside the block.
// ============================================================================
module block_average_piecewise_temperature_top_tb;
    import bapt_pkg::*;

    localparam int SAMPLE_COUNT     = 16;
    localparam int TARGET_WORDS     = 1250;
    localparam int SETTLE_CYCLES    = 24;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_SAMPLE       = 4095;

    logic                      clk             = 1'b0;
    logic                      rst_n           = 1'b0;
    logic                      sample_valid    = 1'b0;
    logic                      sample_ready;
    logic [SAMPLE_W-1:0]       sample_ch0      = '0;
    logic [SAMPLE_W-1:0]       sample_ch1      = '0;
    logic                      result_valid;
    logic                      result_ready    = 1'b0;
    logic [SAMPLE_W-1:0]       average_ch0;
    logic [SAMPLE_W-1:0]       average_ch1;
    logic signed [TEMP_W-1:0]  temperature_ch0;
    logic signed [TEMP_W-1:0]  temperature_ch1;

    int unsigned mismatch_count;
    int unsigned readings_pending;
    int unsigned words_sent = 0;
    int          burst_left = 0;

    block_average_piecewise_temperature_top #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample_ch0      (sample_ch0),
        .sample_ch1      (sample_ch1),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .average_ch0     (average_ch0),
        .average_ch1     (average_ch1),
        .temperature_ch0 (temperature_ch0),
        .temperature_ch1 (temperature_ch1)
    );

    bapt_reading_checker #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) reading_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .sample_ch0       (sample_ch0),
        .sample_ch1       (sample_ch1),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .average_ch0      (average_ch0),
        .average_ch1      (average_ch1),
        .temperature_ch0  (temperature_ch0),
        .temperature_ch1  (temperature_ch1),
        .mismatch_count   (mismatch_count),
        .readings_pending (readings_pending)
    );

    // 4 ns clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Segment edges and the scale ends, used as block levels
    function automatic int knee_value(input int idx);
        unique case (idx)
            0:       return 0;
            1:       return 796;
            2:       return 1192;
            3:       return 2536;
            4:       return 3058;
            5:       return 3424;
            6:       return 3470;
            7:       return MAX_SAMPLE;
            default: return 2048;
        endcase
    endfunction

    // One sample of a block: full random, flat level, level with noise, low range
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode, input int level);
        int lvl;
        unique case (mode)
            0:       lvl = int'($urandom_range(0, MAX_SAMPLE));
            1:       lvl = level;
            2:       lvl = level + int'($urandom_range(0, 6)) - 3;
            default: lvl = int'($urandom_range(0, 1000));
        endcase
        if (lvl < 0)
            lvl = 0;
        if (lvl > MAX_SAMPLE)
            lvl = MAX_SAMPLE;
        return lvl[SAMPLE_W-1:0];
    endfunction

    // Offer one word; bursts of random length with random gaps between them
    task automatic send_word(input logic [SAMPLE_W-1:0] c0, input logic [SAMPLE_W-1:0] c1);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        sample_valid <= 1'b1;
        sample_ch0   <= c0;
        sample_ch1   <= c1;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        int mode0;
        int mode1;
        int level0;
        int level1;
        int drain;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // full scale on ch0, zero on ch1; the emitting word carries samples to drop
        repeat (SAMPLE_COUNT) send_word('1, '0);
        send_word('1, '1);

        // random blocks, levels aimed at the segment edges
        while (words_sent < TARGET_WORDS)
        begin
            mode0  = $urandom_range(0, 3);
            mode1  = $urandom_range(0, 3);
            level0 = knee_value($urandom_range(0, 7)) + int'($urandom_range(0, 2)) - 1;
            level1 = knee_value($urandom_range(0, 7)) + int'($urandom_range(0, 2)) - 1;
            repeat (SAMPLE_COUNT) send_word(pick_sample(mode0, level0),
                                            pick_sample(mode1, level1));
            send_word(SAMPLE_W'($urandom_range(0, MAX_SAMPLE)),
                      SAMPLE_W'($urandom_range(0, MAX_SAMPLE)));
        end
        sample_valid <= 1'b0;

        // let the clock advance so the pending count includes the last emitting word
        @(posedge clk);

        // drain outstanding readings, then let the pipeline settle
        drain = 0;
        while (readings_pending != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && readings_pending == 0)
            $display("block_average_piecewise_temperature_top test passed");
        else
            $display("block_average_piecewise_temperature_top test failed");
        $finish;
    end

    // Result side: stretches of always-ready, half, mostly stalled, and long holds
    initial
    begin : result_sink
        int stretch;
        int mode;
        stretch = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (stretch % 10 == 3)
            begin
                // long hold-off: block fills up and backs up the sample side
                repeat (LONG_HOLD_CYCLES)
                begin
                    @(posedge clk);
                    result_ready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 2);
                repeat ($urandom_range(20, 200))
                begin
                    @(posedge clk);
                    unique case (mode)
                        0:       result_ready <= 1'b1;
                        1:       result_ready <= ($urandom_range(0, 1) == 0);
                        default: result_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
            stretch++;
        end
    end

    // Run limit
    initial
    begin : run_limit
        #2_000_000;
        $display("block_average_piecewise_temperature_top test failed");
        $finish;
    end

endmodule
